FILE: rtl/three_channel_root_counter_macros.svh
// assertion macros for the root counter block
`ifndef THREE_CHANNEL_ROOT_COUNTER_MACROS_SVH
`define THREE_CHANNEL_ROOT_COUNTER_MACROS_SVH

`ifndef SYNTHESIS

// condition holds in the same cycle as the trigger
`define TCRC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("root counter assertion failed");

// condition holds in the cycle after the trigger
`define TCRC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("root counter assertion failed");

`else

`define TCRC_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define TCRC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: rtl/tcrc_pkg.sv
`default_nettype none

package tcrc_pkg;

    localparam int NUM_TIMERS = 3;

    // operation codes
    localparam logic [3:0] OP_TICK         = 4'd0;
    localparam logic [3:0] OP_HBLANK_START = 4'd1;
    localparam logic [3:0] OP_HBLANK_END   = 4'd2;
    localparam logic [3:0] OP_VBLANK_START = 4'd3;
    localparam logic [3:0] OP_VBLANK_END   = 4'd4;
    localparam logic [3:0] OP_WR_COUNT     = 4'd5;
    localparam logic [3:0] OP_WR_MODE      = 4'd6;
    localparam logic [3:0] OP_WR_TARGET    = 4'd7;
    localparam logic [3:0] OP_RD_COUNT     = 4'd8;
    localparam logic [3:0] OP_RD_MODE      = 4'd9;
    localparam logic [3:0] OP_RD_TARGET    = 4'd10;

    // timer index that addresses no timer
    localparam logic [1:0] TIMER_NONE = 2'd3;

    // status flag bit positions
    localparam int FL_PAUSED = 0;
    localparam int FL_REQ    = 1;
    localparam int FL_TGT    = 2;
    localparam int FL_WRAP   = 3;
    localparam int FL_TRIG   = 4;

    // sync mode codes
    localparam logic [1:0] SYNC_PAUSE   = 2'd0;
    localparam logic [1:0] SYNC_RESET   = 2'd1;
    localparam logic [1:0] SYNC_WINDOW  = 2'd2;
    localparam logic [1:0] SYNC_RELEASE = 2'd3;

    localparam logic [3:0]  GPU_CPD_RESET = 4'd7;
    localparam logic [3:0]  GPU_CPD_MIN   = 4'd2;
    localparam logic [7:0]  DOT_STEP      = 8'd11;
    localparam logic [16:0] TARGET_FULL   = 17'h10000;
    localparam logic [16:0] COUNT_WRAP    = 17'h0FFFF;

    typedef struct packed {
        logic [15:0] count;
        logic [16:0] target;
        logic [9:0]  mode;
        logic [4:0]  flags;
    } timer_t;

    typedef struct packed {
        timer_t tm;
        logic   raised;
    } count_res_t;

endpackage

`default_nettype wire

FILE: rtl/three_channel_root_counter.sv
// Three 16-bit root counters with mode, target and status registers.
// Input channel (s_): one item per system tick, blank edge or register
// access; s_tuser holds operation and timer index, s_tdata the write value.
// Result channel (m_): exactly one item per input item, carrying the read
// value in m_tdata and the three interrupt pulses plus hblank_wanted in
// m_tuser. Configuration channel (cfg_): sets the dot rate and
// clears the dot accumulator; always ready.
// The result is registered and is valid in the cycle after the input item is accepted.
// Throughput: one item per cycle while results are taken; all timer state is updated in a single
// pass of logic from the accepted item into the state and result registers.
// A stalled receiver holds the result register; s_tready then drops until
// the result is taken, and rises again in the cycle m_tready is seen.
// Reset (aresetn low, synchronous): counters cleared, targets 0x10000,
// modes and flags cleared, dot rate 7, no result pending.
`default_nettype none
`include "three_channel_root_counter_macros.svh"

module three_channel_root_counter (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // config write: gpu_cycles_per_dot
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [3:0]  cfg_data,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] write_data
    input  wire logic [5:0]  s_tuser,   // [3:0] operation, [5:4] timer_index
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [15:0] read_data
    output logic [3:0]       m_tuser    // [0] irq_timer0, [1] irq_timer1,
                                        // [2] irq_timer2, [3] hblank_wanted
);
    import tcrc_pkg::*;

    timer_t      timer_reg  [NUM_TIMERS];
    timer_t      timer_next [NUM_TIMERS];
    logic [6:0]  dot_acc_reg;
    logic [6:0]  dot_acc_next;
    logic [2:0]  prescale_reg;
    logic [2:0]  prescale_next;
    logic [3:0]  gpu_cpd_reg;
    logic        m_tvalid_reg;
    logic [15:0] rd_data_reg;
    logic [15:0] rd_data_next;
    logic [3:0]  flags_out_reg;
    logic [3:0]  flags_out_next;

    logic        in_acc;
    logic [3:0]  op;
    logic [1:0]  tsel;
    logic [15:0] wdata;
    logic [3:0]  dot_eff;
    logic [6:0]  period;
    logic [7:0]  acc_sum;
    logic [7:0]  acc_sub;
    logic        dot_now;
    logic        div_now;
    logic [2:0]  irq;

    // one counting step of a timer
    function automatic count_res_t count_step(input timer_t tm);
        count_res_t  res;
        logic [16:0] nxt;
        logic        ev;
        begin
            res        = '0;
            res.tm     = tm;
            ev         = 1'b0;
            nxt        = {1'b0, tm.count} + 17'd1;
            // a pulse irq drops first, even while paused
            if (res.tm.flags[FL_REQ] && !tm.mode[7]) begin
                res.tm.flags[FL_REQ] = 1'b0;
            end
            if (!res.tm.flags[FL_PAUSED]) begin
                res.tm.count = nxt[15:0];
                if (nxt == tm.target) begin
                    res.tm.flags[FL_TGT] = 1'b1;
                    if (tm.mode[3]) begin
                        res.tm.count = '0;
                    end
                    if (tm.mode[4]) begin
                        ev = 1'b1;
                    end
                end
                if (nxt == COUNT_WRAP) begin
                    res.tm.flags[FL_WRAP] = 1'b1;
                    if (tm.mode[5]) begin
                        ev = 1'b1;
                    end
                end
                if (ev && !(!tm.mode[6] && res.tm.flags[FL_TRIG])) begin
                    res.tm.flags[FL_TRIG] = 1'b1;
                    if (tm.mode[7]) begin
                        res.tm.flags[FL_REQ] = ~res.tm.flags[FL_REQ];
                    end else begin
                        res.tm.flags[FL_REQ] = 1'b1;
                    end
                    res.raised = res.tm.flags[FL_REQ];
                end
            end
            return res;
        end
    endfunction

    // sync handling on a blank edge
    function automatic timer_t blank_edge(input timer_t tm, input logic start);
        timer_t     t;
        logic [1:0] sync;
        begin
            t    = tm;
            sync = tm.mode[2:1];
            if (tm.mode[0]) begin
                if (start) begin
                    case (sync)
                        SYNC_PAUSE: begin
                            t.flags[FL_PAUSED] = 1'b1;
                        end
                        SYNC_RELEASE: begin
                            t.flags[FL_PAUSED] = 1'b0;
                            t.mode[0]          = 1'b0;
                        end
                        default: begin
                            t.flags[FL_PAUSED] = 1'b0;
                            t.count            = '0;
                        end
                    endcase
                end else begin
                    case (sync)
                        SYNC_PAUSE:  t.flags[FL_PAUSED] = 1'b0;
                        SYNC_WINDOW: t.flags[FL_PAUSED] = 1'b1;
                        default:     t = t;
                    endcase
                end
            end
            return t;
        end
    endfunction

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign in_acc    = s_tvalid && s_tready;
    assign op        = s_tuser[3:0];
    assign tsel      = s_tuser[5:4];
    assign wdata     = s_tdata;

    // dot clock accumulator and divide-by-8 prescaler
    assign dot_eff = (gpu_cpd_reg < GPU_CPD_MIN) ? GPU_CPD_MIN : gpu_cpd_reg;
    assign period  = {dot_eff, 3'b000} - {3'b000, dot_eff};
    assign acc_sum = {1'b0, dot_acc_reg} + DOT_STEP;
    assign dot_now = acc_sum >= {1'b0, period};
    assign acc_sub = acc_sum - {1'b0, period};
    assign div_now = (prescale_reg == 3'd7);

    // item processing
    always_comb begin
        count_res_t cr0;
        count_res_t cr1;
        count_res_t cr2;
        timer_t     sel;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            timer_next[i] = timer_reg[i];
        end
        dot_acc_next  = dot_acc_reg;
        prescale_next = prescale_reg;
        rd_data_next  = '0;
        irq           = '0;
        cr0           = count_step(timer_reg[0]);
        cr1           = count_step(timer_reg[1]);
        cr2           = count_step(timer_reg[2]);
        sel           = timer_reg[tsel];
        case (op)
            OP_TICK: begin
                dot_acc_next  = dot_now ? acc_sub[6:0] : acc_sum[6:0];
                prescale_next = prescale_reg + 3'd1;
                if (!timer_reg[0].mode[8] || dot_now) begin
                    timer_next[0] = cr0.tm;
                    irq[0]        = cr0.raised;
                end
                if (!timer_reg[1].mode[8]) begin
                    timer_next[1] = cr1.tm;
                    irq[1]        = cr1.raised;
                end
                if (!timer_reg[2].mode[9] || div_now) begin
                    timer_next[2] = cr2.tm;
                    irq[2]        = cr2.raised;
                end
            end
            OP_HBLANK_START: begin
                timer_next[0] = blank_edge(timer_reg[0], 1'b1);
                if (timer_reg[1].mode[8]) begin
                    timer_next[1] = cr1.tm;
                    irq[1]        = cr1.raised;
                end
            end
            OP_HBLANK_END:   timer_next[0] = blank_edge(timer_reg[0], 1'b0);
            OP_VBLANK_START: timer_next[1] = blank_edge(timer_reg[1], 1'b1);
            OP_VBLANK_END:   timer_next[1] = blank_edge(timer_reg[1], 1'b0);
            OP_WR_COUNT: begin
                if (tsel != TIMER_NONE) begin
                    timer_next[tsel].count = wdata;
                end
            end
            OP_WR_MODE: begin
                if (tsel != TIMER_NONE) begin
                    timer_next[tsel].mode  = wdata[9:0];
                    timer_next[tsel].count = '0;
                    timer_next[tsel].flags = '0;
                    if (wdata[0] && (wdata[2:1] == SYNC_RELEASE
                        || (tsel == 2'd2 && wdata[2:1] == SYNC_PAUSE))) begin
                        timer_next[tsel].flags[FL_PAUSED] = 1'b1;
                    end
                end
            end
            OP_WR_TARGET: begin
                if (tsel != TIMER_NONE) begin
                    timer_next[tsel].target = (wdata == 16'd0) ? TARGET_FULL
                                                               : {1'b0, wdata};
                end
            end
            OP_RD_COUNT: begin
                if (tsel != TIMER_NONE) begin
                    rd_data_next = sel.count;
                end
            end
            OP_RD_MODE: begin
                if (tsel != TIMER_NONE) begin
                    rd_data_next = {3'b000, sel.flags[FL_WRAP], sel.flags[FL_TGT],
                                    !sel.flags[FL_REQ], sel.mode};
                    timer_next[tsel].flags[FL_TGT]  = 1'b0;
                    timer_next[tsel].flags[FL_WRAP] = 1'b0;
                end
            end
            OP_RD_TARGET: begin
                if (tsel != TIMER_NONE) begin
                    rd_data_next = sel.target[15:0];
                end
            end
            default: rd_data_next = '0;
        endcase
        flags_out_next = {timer_next[0].mode[0] || timer_next[1].mode[8], irq};
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
                timer_reg[i].count  <= '0;
                timer_reg[i].target <= TARGET_FULL;
                timer_reg[i].mode   <= '0;
                timer_reg[i].flags  <= '0;
            end
            dot_acc_reg  <= '0;
            prescale_reg <= '0;
            gpu_cpd_reg  <= GPU_CPD_RESET;
        end else begin
            if (in_acc) begin
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    timer_reg[i] <= timer_next[i];
                end
                dot_acc_reg  <= dot_acc_next;
                prescale_reg <= prescale_next;
            end
            if (cfg_valid) begin
                gpu_cpd_reg <= cfg_data;
                dot_acc_reg <= '0;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_tready) begin
            m_tvalid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            rd_data_reg   <= rd_data_next;
            flags_out_reg <= flags_out_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = rd_data_reg;
    assign m_tuser  = flags_out_reg;

    // checks
    `TCRC_ASSERT_NEXT(a_result_follows, aclk, aresetn, in_acc, m_tvalid)
    `TCRC_ASSERT_NEXT(a_no_read_zero, aclk, aresetn, in_acc && op < OP_RD_COUNT, m_tdata == 16'd0)
    `TCRC_ASSERT_NEXT(a_irq_source, aclk, aresetn, in_acc && op != OP_TICK && op != OP_HBLANK_START, m_tuser[2:0] == 3'b000)
    `TCRC_ASSERT_NOW(a_dot_acc_range, aclk, aresetn, 1'b1, dot_acc_reg < period)

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tcrc_pkg::*;

    // mode word masks
    localparam logic [9:0] MODE_SYNC_EN  = 10'h001;
    localparam logic [9:0] MODE_RST_TGT  = 10'h008;
    localparam logic [9:0] MODE_IRQ_TGT  = 10'h010;
    localparam logic [9:0] MODE_IRQ_WRAP = 10'h020;
    localparam logic [9:0] MODE_REPEAT   = 10'h040;
    localparam logic [9:0] MODE_TOGGLE   = 10'h080;
    localparam logic [9:0] MODE_SRC0     = 10'h100;

    // codes that select no operation
    localparam logic [3:0] OP_UNUSED_LO = 4'd11;
    localparam logic [3:0] OP_UNUSED_HI = 4'd15;

    // dot rate per random block, block 0 in the low nibble; every fourth is random
    localparam logic [47:0] DOT_PLAN = 48'h0F320F71002F;

    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic [15:0] read_data;
        logic [2:0]  irq;          // bit n: timer n
        logic        hblank_wanted;
    } counter_out_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_data = 4'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = 16'd0;   // [15:0] write_data
    logic [5:0]  s_tuser = 6'd0;    // [3:0] operation, [5:4] timer_index
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [15:0] read_data
    logic [3:0]  m_tuser;           // [0] irq0, [1] irq1, [2] irq2, [3] hblank_wanted

    int src_idle_pct = 21;
    int sink_idle_pct = 75;
    int errors = 0;

    // timer state as the block should hold it
    logic [15:0] tm_count [3] = '{16'd0, 16'd0, 16'd0};
    logic [16:0] tm_target [3] = '{TARGET_FULL, TARGET_FULL, TARGET_FULL};
    logic [9:0]  tm_mode [3] = '{10'd0, 10'd0, 10'd0};
    logic [4:0]  tm_flags [3] = '{5'd0, 5'd0, 5'd0};
    logic [6:0]  dot_acc = 7'd0;
    logic [2:0]  prescale = 3'd0;
    logic [3:0]  dot_rate = GPU_CPD_RESET;

    counter_out_t due_outputs [$];

    three_channel_root_counter u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // clock, 10 ns period
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // receiver stalls
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    task automatic report_error(input string what);
        errors++;
        if (errors <= MAX_PRINTED) $display("%0t: error: %s", $time, what);
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] want);
        if (got !== want) report_error($sformatf("%s got %h want %h", name, got, want));
    endtask

    // one counting step of timer t, returns 1 when its irq is raised
    function automatic logic tick_timer(input int t);
        logic [4:0]  fl;
        logic [9:0]  md;
        logic [16:0] nxt;
        logic        ev;
        logic        raised;
        fl = tm_flags[t];
        md = tm_mode[t];
        ev = 1'b0;
        raised = 1'b0;
        // a pulse irq lasts one step, even while paused
        if (fl[FL_REQ] && (md & MODE_TOGGLE) == 0) fl[FL_REQ] = 1'b0;
        if (!fl[FL_PAUSED]) begin
            nxt = {1'b0, tm_count[t]} + 17'd1;
            tm_count[t] = nxt[15:0];
            if (nxt == tm_target[t]) begin
                fl[FL_TGT] = 1'b1;
                if ((md & MODE_RST_TGT) != 0) tm_count[t] = 16'd0;
                if ((md & MODE_IRQ_TGT) != 0) ev = 1'b1;
            end
            if (nxt == COUNT_WRAP) begin
                fl[FL_WRAP] = 1'b1;
                if ((md & MODE_IRQ_WRAP) != 0) ev = 1'b1;
            end
            // one-shot mode fires only once per mode write
            if (ev && !((md & MODE_REPEAT) == 0 && fl[FL_TRIG])) begin
                fl[FL_TRIG] = 1'b1;
                if ((md & MODE_TOGGLE) != 0) fl[FL_REQ] = !fl[FL_REQ];
                else fl[FL_REQ] = 1'b1;
                raised = fl[FL_REQ];
            end
        end
        tm_flags[t] = fl;
        return raised;
    endfunction

    // blank edge seen by timer t (0 on hblank, 1 on vblank)
    function automatic void blank_edge(input int t, input logic start);
        logic [9:0] md;
        md = tm_mode[t];
        if ((md & MODE_SYNC_EN) == 0) return;
        if (start) begin
            if (md[2:1] == SYNC_PAUSE) begin
                tm_flags[t][FL_PAUSED] = 1'b1;
            end else if (md[2:1] == SYNC_RELEASE) begin
                tm_flags[t][FL_PAUSED] = 1'b0;
                tm_mode[t] = md & ~MODE_SYNC_EN;
            end else begin
                tm_flags[t][FL_PAUSED] = 1'b0;
                tm_count[t] = 16'd0;
            end
        end else begin
            if (md[2:1] == SYNC_PAUSE) tm_flags[t][FL_PAUSED] = 1'b0;
            else if (md[2:1] == SYNC_WINDOW) tm_flags[t][FL_PAUSED] = 1'b1;
        end
    endfunction

    // outputs caused by one accepted item, state updated on the way
    function automatic counter_out_t step_counters(input logic [3:0] op, input logic [1:0] ti,
                                                   input logic [15:0] data);
        counter_out_t res;
        int           t;
        int           dot;
        int           period;
        int           acc;
        logic         dot_now;
        logic         div_now;
        logic [9:0]   md;
        logic [4:0]   fl;
        res = '0;
        t = int'(ti);
        dot_now = 1'b0;
        div_now = 1'b0;
        case (op)
            OP_TICK: begin
                // dot clock from the accumulator, timer 2 divided clock from the prescaler
                dot = int'((dot_rate < GPU_CPD_MIN) ? GPU_CPD_MIN : dot_rate);
                period = 7 * dot;
                acc = int'(dot_acc) + int'(DOT_STEP);
                if (acc >= period) begin
                    acc -= period;
                    dot_now = 1'b1;
                end
                dot_acc = acc[6:0];
                if (prescale >= 3'd7) begin
                    prescale = 3'd0;
                    div_now = 1'b1;
                end else begin
                    prescale = prescale + 3'd1;
                end
                if ((tm_mode[0] & MODE_SRC0) == 0 || dot_now) res.irq[0] = tick_timer(0);
                if ((tm_mode[1] & MODE_SRC0) == 0) res.irq[1] = tick_timer(1);
                if (tm_mode[2][9:8] < 2'd2 || div_now) res.irq[2] = tick_timer(2);
            end
            OP_HBLANK_START: begin
                blank_edge(0, 1'b1);
                if ((tm_mode[1] & MODE_SRC0) != 0) res.irq[1] = tick_timer(1);
            end
            OP_HBLANK_END:   blank_edge(0, 1'b0);
            OP_VBLANK_START: blank_edge(1, 1'b1);
            OP_VBLANK_END:   blank_edge(1, 1'b0);
            OP_WR_COUNT: begin
                if (ti != TIMER_NONE) tm_count[t] = data;
            end
            OP_WR_MODE: begin
                if (ti != TIMER_NONE) begin
                    md = data[9:0];
                    tm_mode[t] = md;
                    tm_count[t] = 16'd0;
                    tm_flags[t] = 5'd0;
                    // release sync pauses at once, timer 2 pause sync never resumes
                    if ((md & MODE_SYNC_EN) != 0 &&
                        (md[2:1] == SYNC_RELEASE || (t == 2 && md[2:1] == SYNC_PAUSE)))
                        tm_flags[t][FL_PAUSED] = 1'b1;
                end
            end
            OP_WR_TARGET: begin
                if (ti != TIMER_NONE)
                    tm_target[t] = (data == 16'd0) ? TARGET_FULL : {1'b0, data};
            end
            OP_RD_COUNT: begin
                if (ti != TIMER_NONE) res.read_data = tm_count[t];
            end
            OP_RD_MODE: begin
                if (ti != TIMER_NONE) begin
                    fl = tm_flags[t];
                    res.read_data = {6'd0, tm_mode[t]};
                    res.read_data[10] = !fl[FL_REQ];
                    res.read_data[11] = fl[FL_TGT];
                    res.read_data[12] = fl[FL_WRAP];
                    // reading the status clears the reached flags
                    fl[FL_TGT] = 1'b0;
                    fl[FL_WRAP] = 1'b0;
                    tm_flags[t] = fl;
                end
            end
            OP_RD_TARGET: begin
                if (ti != TIMER_NONE) res.read_data = tm_target[t][15:0];
            end
            default: ;
        endcase
        res.hblank_wanted = ((tm_mode[0] & MODE_SYNC_EN) != 0) ||
                            ((tm_mode[1] & MODE_SRC0) != 0);
        return res;
    endfunction

    // result check, then config and input items seen at this edge
    always @(posedge aclk) begin : monitor
        counter_out_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (due_outputs.size() == 0) begin
                    report_error("result item with none expected");
                end else begin
                    want = due_outputs.pop_front();
                    compare_field("read_data", m_tdata, want.read_data);
                    compare_field("irq_timer0", 16'(m_tuser[0]), 16'(want.irq[0]));
                    compare_field("irq_timer1", 16'(m_tuser[1]), 16'(want.irq[1]));
                    compare_field("irq_timer2", 16'(m_tuser[2]), 16'(want.irq[2]));
                    compare_field("hblank_wanted", 16'(m_tuser[3]),
                                  16'(want.hblank_wanted));
                end
            end
            if (cfg_valid && cfg_ready) begin
                dot_rate = cfg_data;
                dot_acc = 7'd0;
            end
            if (s_tvalid && s_tready)
                due_outputs.push_back(step_counters(s_tuser[3:0], s_tuser[5:4], s_tdata));
        end
    end

    task automatic send_item(input logic [3:0] op, input logic [1:0] ti, input logic [15:0] data);
        // random gap with junk on the bus
        while ($urandom_range(0, 99) < src_idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            s_tdata <= 16'($urandom);
            s_tuser <= 6'($urandom);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= data;
        s_tuser <= {ti, op};
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop sending and let every result drain
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (due_outputs.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_dot_rate(input logic [3:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] random_mode();
        logic [15:0] m;
        m = 16'($urandom);
        if ($urandom_range(0, 1) != 0) m[0] = 1'b0;
        return m;
    endfunction

    // register extremes, timer index three, unused code
    task automatic test_register_access();
        send_item(OP_WR_COUNT, 2'd0, 16'hFFFF);
        send_item(OP_RD_COUNT, 2'd0, 16'h0000);
        send_item(OP_WR_TARGET, 2'd1, 16'h0000);
        send_item(OP_RD_TARGET, 2'd1, 16'h0000);
        send_item(OP_WR_MODE, 2'd2, 16'hFFFF);
        send_item(OP_RD_MODE, 2'd2, 16'h0000);
        send_item(OP_WR_COUNT, TIMER_NONE, 16'hA5A5);
        send_item(OP_RD_COUNT, TIMER_NONE, 16'hFFFF);
        send_item(OP_UNUSED_HI, 2'd0, 16'hFFFF);
    endtask

    // target reset with repeated pulse, wrap with toggle
    task automatic test_target_and_wrap();
        send_item(OP_WR_TARGET, 2'd1, 16'd2);
        send_item(OP_WR_MODE, 2'd1, 16'(MODE_RST_TGT | MODE_IRQ_TGT | MODE_REPEAT));
        send_item(OP_TICK, 2'd0, 16'd0);
        send_item(OP_TICK, 2'd0, 16'd0);
        send_item(OP_WR_MODE, 2'd0, 16'(MODE_IRQ_WRAP | MODE_TOGGLE));
        send_item(OP_WR_COUNT, 2'd0, 16'hFFFE);
        send_item(OP_TICK, 2'd0, 16'd0);
        send_item(OP_RD_MODE, 2'd0, 16'd0);
    endtask

    // pause on hblank, release on vblank, timer 2 stuck in pause sync
    task automatic test_sync_modes();
        send_item(OP_WR_MODE, 2'd0, 16'(MODE_SYNC_EN));
        send_item(OP_HBLANK_START, 2'd0, 16'd0);
        send_item(OP_TICK, 2'd0, 16'd0);
        send_item(OP_HBLANK_END, 2'd0, 16'd0);
        send_item(OP_WR_MODE, 2'd1, 16'(MODE_SYNC_EN | MODE_SRC0 | {7'd0, SYNC_RELEASE, 1'b0}));
        send_item(OP_VBLANK_START, 2'd0, 16'd0);
        send_item(OP_HBLANK_START, 2'd0, 16'd0);
        send_item(OP_VBLANK_END, 2'd0, 16'd0);
        send_item(OP_WR_MODE, 2'd2, 16'(MODE_SYNC_EN));
        send_item(OP_TICK, 2'd0, 16'd0);
    endtask

    // dot clock with a rate setting below the minimum
    task automatic test_dot_rate();
        wait_idle();
        write_dot_rate(4'd0);
        send_item(OP_WR_MODE, 2'd0, 16'(MODE_SRC0));
        repeat (3) send_item(OP_TICK, 2'd0, 16'd0);
    endtask

    // timer setups with near-target counts, then mixed traffic
    task automatic test_random_traffic();
        logic [3:0]  op;
        logic [1:0]  ti;
        logic [15:0] data;
        logic [15:0] tgt;
        int          r;
        for (int blk = 0; blk < 12; blk++) begin
            src_idle_pct = (blk < 4) ? 21 : ((blk < 8) ? 75 : 0);
            sink_idle_pct = (blk < 4) ? 75 : ((blk < 8) ? 21 : 0);
            wait_idle();
            write_dot_rate((blk % 4 == 3) ? 4'($urandom_range(0, 15)) : DOT_PLAN[blk*4 +: 4]);
            for (int i = 0; i < 120; i++) begin
                if (i % 40 == 0) begin
                    // mode, a target (mostly small) and a count just short of target or wrap
                    ti = 2'($urandom_range(0, 2));
                    tgt = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(1, 24)) : 16'($urandom);
                    send_item(OP_WR_MODE, ti, random_mode());
                    send_item(OP_WR_TARGET, ti, tgt);
                    send_item(OP_WR_COUNT, ti, ($urandom_range(0, 1) != 0) ?
                              tgt - 16'($urandom_range(1, 6)) :
                              16'hFFFF - 16'($urandom_range(0, 6)));
                    i += 2;
                end else begin
                    r = $urandom_range(0, 99);
                    ti = 2'($urandom_range(0, 3));
                    data = 16'($urandom);
                    if (r < 52) begin
                        op = OP_TICK;
                    end else if (r < 64) begin
                        op = 4'($urandom_range(OP_HBLANK_START, OP_VBLANK_END));
                    end else if (r < 78) begin
                        op = 4'($urandom_range(OP_RD_COUNT, OP_RD_TARGET));
                    end else if (r < 92) begin
                        op = 4'($urandom_range(OP_WR_COUNT, OP_WR_TARGET));
                        if (op == OP_WR_MODE) data = random_mode();
                        else if (op == OP_WR_TARGET && r < 88)
                            data = 16'($urandom_range(0, 24));
                        else if (op == OP_WR_COUNT && r < 85)
                            data = 16'hFFFF - 16'($urandom_range(0, 10));
                    end else if (r < 94) begin
                        op = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
                    end else begin
                        // extra hblank starts feed timer 1 in hblank clock mode
                        op = OP_HBLANK_START;
                    end
                    send_item(op, ti, data);
                end
            end
        end
    endtask

    // test sequence
    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_register_access();
        test_target_and_wrap();
        test_sync_modes();
        test_dot_rate();
        test_random_traffic();
        wait_idle();
        repeat (4) @(posedge aclk);
        if (errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    // run limit
    initial begin
        #2000000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
